FILE: hw/rtl/pbd_pkg.sv
// Shared constants and codes for the ploidy birth-death step core.
// Used by ploidy_birth_death_step_core and the testbench; no dependencies.
package pbd_pkg;

  // Default sizing of the level histogram.
  localparam int NUM_LEVELS_DEF = 30;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths at the ports.
  localparam int MODE_W     = 2;
  localparam int DRAW_W     = 16;
  localparam int LEVEL_W    = 5;
  localparam int EVENT_W    = 3;
  localparam int FCOUNT_W   = 16;
  localparam int THR_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_STEP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;

  // Result event codes.
  localparam logic [EVENT_W-1:0] EV_HOMOPLOID = 3'd0;
  localparam logic [EVENT_W-1:0] EV_POLYPLOID = 3'd1;
  localparam logic [EVENT_W-1:0] EV_EXTINCT   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_DIED      = 3'd3;
  localparam logic [EVENT_W-1:0] EV_TARGET    = 3'd4;
  localparam logic [EVENT_W-1:0] EV_BAD_DRAW  = 3'd5;
  localparam logic [EVENT_W-1:0] EV_RESTARTED = 3'd6;
  localparam logic [EVENT_W-1:0] EV_READ      = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_POP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_THR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_THR    = 2'd3;

  // Configuration reset values.
  localparam logic [FCOUNT_W-1:0] START_COUNT_RST = 16'd10;
  localparam logic [FCOUNT_W-1:0] TARGET_POP_RST  = 16'd1000;
  localparam logic [THR_W-1:0]    SPLIT_THR_RST   = 17'd32768;
  localparam logic [THR_W-1:0]    POLY_THR_RST    = 17'd16384;

endpackage

FILE: hw/rtl/pbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; instantiated by ploidy_birth_death_step_core.
module pbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ploidy_birth_death_step_core.sv
// Top level of the ploidy birth-death step core: control sequencer, population
// register and configuration. Depends on pbd_pkg and pbd_ram.
//
// Usage. Items enter on the in_ channel (valid/ready) and each item produces
// exactly one result item on the out_ channel (valid/ready). Mode 0 performs
// one birth-death step from the three supplied draws, mode 1 reloads the
// start state (start_count in level zero), and mode 2 (or 3) reads one level
// count. Configuration registers are written through cfg_we/cfg_index/
// cfg_wdata and must only be changed while the core is idle.
//
// Timing. The level histogram lives in a synchronous RAM with registered read
// data. A step walks the cumulative sum one level per cycle, updates the picked
// level and then completes its result. A read waits for the read data (a read
// past the last level does not), while a restart or a flagged step (target
// reached, bad draw) goes straight to its result.
// The core handles one item at a time and takes the next item on the cycle
// after its result is loaded into the output register, even if that result
// has not been taken yet.
//
// Reset clears the histogram through per-level valid bits, sets the population
// to zero and loads the configuration defaults. When the receiver stalls, the
// output register holds its result and the core waits before loading the next.
module ploidy_birth_death_step_core #(
  parameter int NUM_LEVELS = pbd_pkg::NUM_LEVELS_DEF,
  parameter int COUNT_BITS = pbd_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input item channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pbd_pkg::MODE_W-1:0]       in_mode,
  input  logic [pbd_pkg::DRAW_W-1:0]       in_bin_draw,
  input  logic [pbd_pkg::DRAW_W-1:0]       in_split_draw,
  input  logic [pbd_pkg::DRAW_W-1:0]       in_polyploid_draw,
  input  logic [pbd_pkg::LEVEL_W-1:0]      in_read_index,
  // Result item channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pbd_pkg::EVENT_W-1:0]      out_event_res,
  output logic [pbd_pkg::LEVEL_W-1:0]      out_level,
  output logic [pbd_pkg::FCOUNT_W-1:0]     out_level_count,
  output logic [pbd_pkg::FCOUNT_W-1:0]     out_population,
  output logic                             out_target_reached,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import pbd_pkg::*;

  // Index, running-sum and comparison widths.
  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int LW2   = (LVL_W > LEVEL_W) ? LVL_W : LEVEL_W;
  localparam int SUM_W = COUNT_BITS + LVL_W;
  localparam int CMP_W = (SUM_W > DRAW_W + 1) ? SUM_W : DRAW_W + 1;
  localparam int CW    = (COUNT_BITS > FCOUNT_W) ? COUNT_BITS : FCOUNT_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LVL_W-1:0]      LAST    = LVL_W'(NUM_LEVELS - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_UPD    = 6'b001000,
    ST_RDWAIT = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  // Control and state registers.
  state_t                 state_r, state_nxt;
  logic [LVL_W-1:0]       idx_r, idx_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [LVL_W-1:0]       pick_r, pick_nxt;
  logic [COUNT_BITS-1:0]  pcnt_r, pcnt_nxt;
  logic [COUNT_BITS-1:0]  pop_r, pop_nxt;
  logic [NUM_LEVELS-1:0]  valid_r, valid_nxt;
  logic [LVL_W-1:0]       raddr_q_r;

  // Latched item fields.
  logic [MODE_W-1:0]      mode_r;
  logic [DRAW_W-1:0]      bin_r;
  logic [DRAW_W-1:0]      split_r;
  logic [DRAW_W-1:0]      pp_r;
  logic [LEVEL_W-1:0]     ridx_r;

  // Pending result, completed with the population in the final state.
  logic [EVENT_W-1:0]     res_ev_r, res_ev_nxt;
  logic [LEVEL_W-1:0]     res_lvl_r, res_lvl_nxt;
  logic [FCOUNT_W-1:0]    res_cnt_r, res_cnt_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [EVENT_W-1:0]     out_ev_r, out_ev_nxt;
  logic [LEVEL_W-1:0]     out_lvl_r, out_lvl_nxt;
  logic [FCOUNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic [FCOUNT_W-1:0]    out_pop_r, out_pop_nxt;
  logic                   out_tgt_r, out_tgt_nxt;

  // Configuration registers.
  logic [FCOUNT_W-1:0]    start_count_r;
  logic [FCOUNT_W-1:0]    target_pop_r;
  logic [THR_W-1:0]       split_thr_r;
  logic [THR_W-1:0]       poly_thr_r;

  // RAM port signals.
  logic                   ram_we;
  logic [LVL_W-1:0]       ram_waddr;
  logic [COUNT_BITS-1:0]  ram_wdata;
  logic [LVL_W-1:0]       ram_raddr;
  logic [COUNT_BITS-1:0]  ram_rdata;

  // Derived values.
  logic                   in_accept;
  logic [COUNT_BITS-1:0]  rd_cnt;
  logic [CW-1:0]          start_ext;
  logic [COUNT_BITS-1:0]  start_sat;
  logic [CW-1:0]          pop_ext;
  logic [LW2-1:0]         pick_ext;
  logic [LW2-1:0]         ridx_ext;
  logic                   ridx_in_range;

  pbd_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_LEVELS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  // An entry that has not been written since reset or restart reads as zero.
  assign rd_cnt = valid_r[raddr_q_r] ? ram_rdata : '0;

  // The start count is saturated to the count width.
  assign start_ext = (CW'(start_count_r) > CW'(CNT_MAX)) ? CW'(CNT_MAX)
                                                         : CW'(start_count_r);
  assign start_sat = start_ext[COUNT_BITS-1:0];

  assign pop_ext       = CW'(pop_r);
  assign pick_ext      = LW2'(pick_r);
  assign ridx_ext      = LW2'(ridx_r);
  assign ridx_in_range = (int'(ridx_r) < NUM_LEVELS);

  // Sequencer: decode, cumulative-sum scan, read-modify-write and result.
  always_comb begin
    logic [SUM_W-1:0]      sum_acc;
    logic                  speciate;
    logic                  up;
    logic [COUNT_BITS-1:0] dcnt;
    logic [COUNT_BITS-1:0] dnew;
    logic [LVL_W-1:0]      dest;
    logic [COUNT_BITS-1:0] ncnt;
    logic [COUNT_BITS-1:0] npop;

    state_nxt   = state_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    pick_nxt    = pick_r;
    pcnt_nxt    = pcnt_r;
    pop_nxt     = pop_r;
    valid_nxt   = valid_r;
    res_ev_nxt  = res_ev_r;
    res_lvl_nxt = res_lvl_r;
    res_cnt_nxt = res_cnt_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;

    out_valid_nxt = out_valid_r && !out_ready;
    out_ev_nxt    = out_ev_r;
    out_lvl_nxt   = out_lvl_r;
    out_cnt_nxt   = out_cnt_r;
    out_pop_nxt   = out_pop_r;
    out_tgt_nxt   = out_tgt_r;

    sum_acc  = sum_r + SUM_W'(rd_cnt);
    speciate = ({1'b0, split_r} < split_thr_r);
    up       = ({1'b0, pp_r} < poly_thr_r) && (pick_r != LAST);
    dcnt     = up ? rd_cnt : pcnt_r;
    dnew     = (dcnt == CNT_MAX) ? dcnt : dcnt + 1'b1;
    dest     = up ? pick_r + 1'b1 : pick_r;
    ncnt     = (pcnt_r == '0) ? pcnt_r : pcnt_r - 1'b1;
    npop     = pop_r - 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (mode_r)
          MODE_RESTART: begin
            ram_we      = 1'b1;
            ram_waddr   = '0;
            ram_wdata   = start_sat;
            valid_nxt   = '0;
            valid_nxt[0] = 1'b1;
            pop_nxt     = start_sat;
            res_ev_nxt  = EV_RESTARTED;
            res_lvl_nxt = '0;
            res_cnt_nxt = start_ext[FCOUNT_W-1:0];
            state_nxt   = ST_FIN;
          end
          MODE_STEP: begin
            if ((pop_ext >= CW'(target_pop_r)) || (pop_r == CNT_MAX)) begin
              res_ev_nxt  = EV_TARGET;
              res_lvl_nxt = '0;
              res_cnt_nxt = '0;
              state_nxt   = ST_FIN;
            end else if (CW'(bin_r) >= pop_ext) begin
              res_ev_nxt  = EV_BAD_DRAW;
              res_lvl_nxt = '0;
              res_cnt_nxt = '0;
              state_nxt   = ST_FIN;
            end else begin
              ram_raddr = '0;
              idx_nxt   = '0;
              sum_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            // Reads (mode 2, and the unused mode 3 behaves the same way).
            res_ev_nxt  = EV_READ;
            res_lvl_nxt = ridx_r;
            if (ridx_in_range) begin
              ram_raddr = ridx_ext[LVL_W-1:0];
              state_nxt = ST_RDWAIT;
            end else begin
              res_cnt_nxt = '0;
              state_nxt   = ST_FIN;
            end
          end
        endcase
      end

      ST_RDWAIT: begin
        res_cnt_nxt = FCOUNT_W'(CW'(rd_cnt));
        state_nxt   = ST_FIN;
      end

      ST_SCAN: begin
        // rd_cnt holds level idx_r; the read of the next level is already
        // under way so the level above a pick is ready for the update.
        sum_nxt   = sum_acc;
        ram_raddr = (idx_r == LAST) ? LAST : idx_r + 1'b1;
        if ((CMP_W'(bin_r) + 1'b1) <= CMP_W'(sum_acc)) begin
          pick_nxt  = idx_r;
          pcnt_nxt  = rd_cnt;
          state_nxt = ST_UPD;
        end else if (idx_r == LAST) begin
          res_ev_nxt  = EV_BAD_DRAW;
          res_lvl_nxt = '0;
          res_cnt_nxt = '0;
          state_nxt   = ST_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_UPD: begin
        res_lvl_nxt = pick_ext[LEVEL_W-1:0];
        state_nxt   = ST_FIN;
        if (speciate) begin
          ram_we          = 1'b1;
          ram_waddr       = dest;
          ram_wdata       = dnew;
          valid_nxt[dest] = 1'b1;
          pop_nxt         = pop_r + 1'b1;
          res_ev_nxt      = up ? EV_POLYPLOID : EV_HOMOPLOID;
          res_cnt_nxt     = FCOUNT_W'(CW'(up ? pcnt_r : dnew));
          if (({1'b0, pp_r} < poly_thr_r) && !up) begin
            // Polyploid speciation at the top level saturates in place.
            res_ev_nxt = EV_POLYPLOID;
          end
        end else if (npop == '0) begin
          // The population died out: reload the start state.
          ram_we       = 1'b1;
          ram_waddr    = '0;
          ram_wdata    = start_sat;
          valid_nxt    = '0;
          valid_nxt[0] = 1'b1;
          pop_nxt      = start_sat;
          res_ev_nxt   = EV_DIED;
          res_cnt_nxt  = (pick_r == '0) ? start_ext[FCOUNT_W-1:0] : '0;
        end else begin
          ram_we            = 1'b1;
          ram_waddr         = pick_r;
          ram_wdata         = ncnt;
          valid_nxt[pick_r] = 1'b1;
          pop_nxt           = npop;
          res_ev_nxt        = EV_EXTINCT;
          res_cnt_nxt       = FCOUNT_W'(CW'(ncnt));
        end
      end

      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = res_ev_r;
          out_lvl_nxt   = res_lvl_r;
          out_cnt_nxt   = res_cnt_r;
          out_pop_nxt   = pop_ext[FCOUNT_W-1:0];
          out_tgt_nxt   = (pop_ext >= CW'(target_pop_r));
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pop_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pop_r       <= pop_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    sum_r     <= sum_nxt;
    pick_r    <= pick_nxt;
    pcnt_r    <= pcnt_nxt;
    raddr_q_r <= ram_raddr;
    res_ev_r  <= res_ev_nxt;
    res_lvl_r <= res_lvl_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_ev_r  <= out_ev_nxt;
    out_lvl_r <= out_lvl_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_pop_r <= out_pop_nxt;
    out_tgt_r <= out_tgt_nxt;
    if (in_accept) begin
      mode_r  <= in_mode;
      bin_r   <= in_bin_draw;
      split_r <= in_split_draw;
      pp_r    <= in_polyploid_draw;
      ridx_r  <= in_read_index;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_count_r <= START_COUNT_RST;
      target_pop_r  <= TARGET_POP_RST;
      split_thr_r   <= SPLIT_THR_RST;
      poly_thr_r    <= POLY_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_COUNT: start_count_r <= cfg_wdata[FCOUNT_W-1:0];
        REG_TARGET_POP:  target_pop_r  <= cfg_wdata[FCOUNT_W-1:0];
        REG_SPLIT_THR:   split_thr_r   <= cfg_wdata[THR_W-1:0];
        REG_POLY_THR:    poly_thr_r    <= cfg_wdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_ev_r;
  assign out_level          = out_lvl_r;
  assign out_level_count    = out_cnt_r;
  assign out_population     = out_pop_r;
  assign out_target_reached = out_tgt_r;

  // The running sum never passes the population, since the population is the
  // sum of all level counts.
  a_scan_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (sum_r <= SUM_W'(pop_r)))
    else $error("cumulative sum exceeds population during scan");

  // An accepted item always goes to the decode state next.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_EXEC))
    else $error("accepted item did not enter decode");

  // A new result only appears after the final state loaded it.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result appeared outside the final state");

  // The histogram is not written while a scan is walking it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("level count written during scan");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for ploidy_birth_death_step_core: drives step, restart and read
// items under several register settings and idle patterns, and checks every result item.
// Depends on pbd_pkg and the core's RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
  import pbd_pkg::*;

  localparam int NUM_LEVELS = NUM_LEVELS_DEF;
  localparam logic [FCOUNT_W-1:0] COUNT_MAX = '1;

  // Mode 2 reads a level; mode 3 is unused and behaves as a read.
  localparam logic [MODE_W-1:0] MODE_READ     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ_ALT = 2'd3;

  // Cycles in which no item moved on either channel, after which the run is declared
  // hung. Sender gaps and receiver stalls are short random runs.
  localparam int WATCHDOG_LIMIT = 2000;
  // Tail waited out at the very end, longer than the slowest item.
  localparam int TAIL_CYCLES = NUM_LEVELS + 10;
  localparam int ITEMS_PER_PHASE = 144;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DRAW_W-1:0]  bin_draw;
    logic [DRAW_W-1:0]  split_draw;
    logic [DRAW_W-1:0]  pp_draw;
    logic [LEVEL_W-1:0] read_index;
  } step_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0]  ev;
    logic [LEVEL_W-1:0]  level;
    logic [FCOUNT_W-1:0] level_count;
    logic [FCOUNT_W-1:0] population;
    logic                target_reached;
  } step_result_t;

  typedef struct {
    int unsigned start_v;
    int unsigned target_v;
    int unsigned split_v;
    int unsigned poly_v;
    int unsigned top_bias;
  } phase_plan_t;

  // The scoreboard keeps its own copy of the level histogram, the population and the
  // registers. Each accepted item is played against that copy, and the result it
  // should produce is queued until the core hands a result item back.
  class ploidy_tracker;
    logic [FCOUNT_W-1:0] counts [NUM_LEVELS];
    logic [FCOUNT_W-1:0] pop_count;
    logic [FCOUNT_W-1:0] start_cnt;
    logic [FCOUNT_W-1:0] target_pop;
    logic [THR_W-1:0]    split_thr;
    logic [THR_W-1:0]    poly_thr;
    step_result_t        awaited [$];
    int                  errors;
    int                  event_tally [8];
    int                  top_level;

    function new();
      foreach (counts[i]) counts[i] = '0;
      pop_count  = '0;
      start_cnt  = START_COUNT_RST;
      target_pop = TARGET_POP_RST;
      split_thr  = SPLIT_THR_RST;
      poly_thr   = POLY_THR_RST;
      errors     = 0;
      top_level  = 0;
      foreach (event_tally[i]) event_tally[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_START_COUNT: start_cnt  = data[FCOUNT_W-1:0];
        REG_TARGET_POP:  target_pop = data[FCOUNT_W-1:0];
        REG_SPLIT_THR:   split_thr  = data[THR_W-1:0];
        REG_POLY_THR:    poly_thr   = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function void reload_start();
      foreach (counts[i]) counts[i] = '0;
      counts[0] = start_cnt;
      pop_count = start_cnt;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void take_item(step_item_t it);
      step_result_t r;
      int unsigned  run_sum;
      int           pick;
      int           dest;
      int           i;
      bit           found;
      r = '0;
      run_sum = 0;
      pick = 0;
      found = 1'b0;
      if (it.mode == MODE_RESTART) begin
        reload_start();
        r.ev = EV_RESTARTED;
        r.level_count = counts[0];
      end else if (it.mode != MODE_STEP) begin
        r.ev = EV_READ;
        r.level = it.read_index;
        r.level_count = (it.read_index < NUM_LEVELS) ? counts[it.read_index] : '0;
      end else if (pop_count >= target_pop || pop_count == COUNT_MAX) begin
        r.ev = EV_TARGET;
      end else if (it.bin_draw >= pop_count) begin
        r.ev = EV_BAD_DRAW;
      end else begin
        for (i = 0; i < NUM_LEVELS && !found; i++) begin
          run_sum += counts[i];
          if (int'(it.bin_draw) + 1 <= run_sum) begin
            pick = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.ev = EV_BAD_DRAW;
        end else begin
          r.level = LEVEL_W'(pick);
          if (it.split_draw < split_thr) begin
            r.ev = EV_HOMOPLOID;
            dest = pick;
            if (it.pp_draw < poly_thr) begin
              r.ev = EV_POLYPLOID;
              if (pick + 1 < NUM_LEVELS) dest = pick + 1;
            end
            if (counts[dest] != COUNT_MAX) counts[dest]++;
            pop_count++;
          end else begin
            if (counts[pick] != 0) counts[pick]--;
            pop_count--;
            r.ev = EV_EXTINCT;
            if (pop_count == 0) begin
              reload_start();
              r.ev = EV_DIED;
            end
          end
          r.level_count = counts[pick];
          if (pick > top_level) top_level = pick;
        end
      end
      r.population = pop_count;
      r.target_reached = (pop_count >= target_pop);
      event_tally[r.ev]++;
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result item with nothing awaited: ev=%0d lvl=%0d cnt=%0d",
                   $realtime, got.ev, got.level, got.level_count,
                   " pop=%0d tgt=%0d", got.population, got.target_reached);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp ev=%0d lvl=%0d cnt=%0d pop=%0d tgt=%0d,",
                   $realtime, want.ev, want.level, want.level_count, want.population,
                   want.target_reached,
                   " got ev=%0d lvl=%0d cnt=%0d pop=%0d tgt=%0d",
                   got.ev, got.level, got.level_count, got.population,
                   got.target_reached);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [MODE_W-1:0]     in_mode;
  logic [DRAW_W-1:0]     in_bin_draw;
  logic [DRAW_W-1:0]     in_split_draw;
  logic [DRAW_W-1:0]     in_polyploid_draw;
  logic [LEVEL_W-1:0]    in_read_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [EVENT_W-1:0]    out_event_res;
  logic [LEVEL_W-1:0]    out_level;
  logic [FCOUNT_W-1:0]   out_level_count;
  logic [FCOUNT_W-1:0]   out_population;
  logic                  out_target_reached;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ploidy_tracker tracker = new();

  // Idle percentages of the sender and the receiver for the current phase.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  ploidy_birth_death_step_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_bin_draw        (in_bin_draw),
    .in_split_draw      (in_split_draw),
    .in_polyploid_draw  (in_polyploid_draw),
    .in_read_index      (in_read_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_level          (out_level),
    .out_level_count    (out_level_count),
    .out_population     (out_population),
    .out_target_reached (out_target_reached),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver side and watchdog. Outputs are sampled at the rising edge, before any of
  // that edge's register updates land, so a result item is taken exactly when valid and
  // ready were both high going into the edge. The watchdog counts edges at which neither
  // channel moved an item; it is the only place the run can end early.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    if (rst_n) begin
      if (out_valid && out_ready)
        tracker.check_result('{out_event_res, out_level, out_level_count,
                               out_population, out_target_reached});
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic step_item_t mk(logic [MODE_W-1:0] m, logic [DRAW_W-1:0] bd,
                                    logic [DRAW_W-1:0] sd, logic [DRAW_W-1:0] pd,
                                    logic [LEVEL_W-1:0] ri);
    step_item_t it;
    it.mode = m;
    it.bin_draw = bd;
    it.split_draw = sd;
    it.pp_draw = pd;
    it.read_index = ri;
    return it;
  endfunction

  // Offers one item and returns at the edge where it is accepted. A random gap with
  // valid low may come first. When there is no gap, valid simply stays high from the
  // previous item, so the line is never lowered and raised within one time step.
  task automatic drive_item(step_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= it.mode;
    in_bin_draw       <= it.bin_draw;
    in_split_draw     <= it.split_draw;
    in_polyploid_draw <= it.pp_draw;
    in_read_index     <= it.read_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_item(it);
    items_sent++;
  endtask

  // Holds the sender off until every awaited result has been taken. Every item gives
  // exactly one result, so the core is idle once the queue is empty.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Writes all four registers on consecutive edges and mirrors them into the tracker.
  task automatic configure(int unsigned start_v, int unsigned target_v,
                           int unsigned split_v, int unsigned poly_v);
    logic [CFG_IDX_W-1:0]  idx_list [4];
    logic [CFG_DATA_W-1:0] val_list [4];
    idx_list = '{REG_START_COUNT, REG_TARGET_POP, REG_SPLIT_THR, REG_POLY_THR};
    val_list = '{start_v[CFG_DATA_W-1:0], target_v[CFG_DATA_W-1:0],
                 split_v[CFG_DATA_W-1:0], poly_v[CFG_DATA_W-1:0]};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_wdata <= val_list[i];
      tracker.write_reg(idx_list[i], val_list[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    phase_plan_t plan [NUM_PHASES];
    step_item_t  it;
    int unsigned r;
    int unsigned b;
    logic [FCOUNT_W-1:0] pop;

    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_mode           <= MODE_STEP;
    in_bin_draw       <= '0;
    in_split_draw     <= '0;
    in_polyploid_draw <= '0;
    in_read_index     <= '0;
    out_ready         <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_START_COUNT;
    cfg_wdata         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset defaults. A step on the empty histogram right after
    // reset is a bad draw; then the boundaries of both thresholds, a draw equal to the
    // population, all-ones draws, and reads of the top level, past the last level and
    // through the unused mode.
    drive_item(mk(MODE_STEP, 16'd0, 16'd0, 16'd0, 5'd0));
    drive_item(mk(MODE_READ, 16'd0, 16'd0, 16'd0, 5'd0));
    drive_item(mk(MODE_RESTART, 16'd0, 16'd0, 16'd0, 5'd0));
    drive_item(mk(MODE_STEP, 16'd9, 16'd0, 16'd0, 5'd0));
    drive_item(mk(MODE_STEP, 16'd10, 16'd32767, 16'd16384, 5'd0));
    drive_item(mk(MODE_STEP, 16'd0, 16'd32768, 16'd0, 5'd0));
    drive_item(mk(MODE_STEP, 16'd11, 16'd0, 16'd0, 5'd0));
    drive_item(mk(MODE_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd0));
    drive_item(mk(MODE_STEP, 16'd0, 16'hFFFF, 16'hFFFF, 5'd0));
    drive_item(mk(MODE_READ, 16'd0, 16'd0, 16'd0, 5'd1));
    drive_item(mk(MODE_READ_ALT, 16'd0, 16'd0, 16'd0, 5'd2));
    drive_item(mk(MODE_READ, 16'd0, 16'd0, 16'd0, 5'd29));
    drive_item(mk(MODE_READ, 16'd0, 16'd0, 16'd0, 5'd30));
    drive_item(mk(MODE_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31));

    // A single individual with no chance to speciate: the next step empties the
    // population and the start state comes back.
    drain();
    configure(1, 1000, 0, 16384);
    drive_item(mk(MODE_RESTART, 16'd0, 16'd0, 16'd0, 5'd0));
    drive_item(mk(MODE_STEP, 16'd0, 16'd0, 16'd0, 5'd0));

    // Thresholds above the draw range: every step speciates polyploid. Target two is
    // reached after one step, so the following step is refused.
    drain();
    configure(1, 2, 65536, 65536);
    drive_item(mk(MODE_RESTART, 16'd0, 16'd0, 16'd0, 5'd0));
    drive_item(mk(MODE_STEP, 16'd0, 16'd0, 16'd0, 5'd0));
    drive_item(mk(MODE_STEP, 16'd0, 16'd0, 16'd0, 5'd0));
    drive_item(mk(MODE_READ, 16'd0, 16'd0, 16'd0, 5'd1));

    // Register settings of the random phases. top_bias is the share of well-formed steps
    // that draw the last individual, which sits in the highest occupied level; with both
    // thresholds at full scale this climbs the histogram up to the saturating top level.
    plan[0] = '{10, 1000, 32768, 16384, 10};
    plan[1] = '{1, 40, 65536, 65536, 90};
    plan[2] = '{1, 65535, 0, 0, 10};
    plan[3] = '{65535, 65535, 40000, 30000, 10};
    plan[4] = '{5, 200, 45000, 50000, 20};
    plan[5] = '{200, 1, 20000, 0, 10};
    plan[6] = '{$urandom_range(1, 65535), $urandom_range(1, 65535),
                $urandom_range(0, 65536), $urandom_range(0, 65536), 15};
    plan[7] = '{3, 60, 36000, 65535, 30};

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      configure(plan[ph].start_v, plan[ph].target_v, plan[ph].split_v, plan[ph].poly_v);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then the sender waits for the core to empty out completely.
        if ($urandom_range(0, 99) < 2) drain();
        pop = tracker.pop_count;
        r = $urandom_range(0, 99);
        it.mode       = MODE_STEP;
        it.bin_draw   = $urandom_range(0, 65535);
        it.split_draw = $urandom_range(0, 65535);
        it.pp_draw    = $urandom_range(0, 65535);
        it.read_index = $urandom_range(0, 31);
        if (r < 5 || (pop >= tracker.target_pop && r < 40)) begin
          it.mode = MODE_RESTART;
        end else if (r < 13) begin
          it.mode = ($urandom_range(0, 1) != 0) ? MODE_READ : MODE_READ_ALT;
        end else if (r >= 19 && pop != 0) begin
          // Well-formed step: the draw lands on a real individual. Otherwise the
          // full-range draw above stands as noise.
          b = $urandom_range(0, 99);
          if (b < plan[ph].top_bias)
            it.bin_draw = pop - 1'b1;
          else if (b < plan[ph].top_bias + 5)
            it.bin_draw = '0;
          else
            it.bin_draw = $urandom_range(0, int'(pop) - 1);
        end
        drive_item(it);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items in a directed part and %0d register settings;",
             items_sent, NUM_PHASES, " deepest level %0d", tracker.top_level);
    $display("events: homoploid %0d polyploid %0d extinct %0d died %0d",
             tracker.event_tally[EV_HOMOPLOID], tracker.event_tally[EV_POLYPLOID],
             tracker.event_tally[EV_EXTINCT], tracker.event_tally[EV_DIED],
             " target %0d bad %0d restart %0d read %0d",
             tracker.event_tally[EV_TARGET], tracker.event_tally[EV_BAD_DRAW],
             tracker.event_tally[EV_RESTARTED], tracker.event_tally[EV_READ]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pbd_pkg.sv
hw/rtl/pbd_ram.sv
hw/rtl/ploidy_birth_death_step_core.sv
sim/tb.sv
